// ----- src/lpkv_pkg.sv -----
// Shared types and constants for the linear probing key/value table.
// No dependencies; imported by every module of the block.
package lpkv_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned KeyW     = 31;
  localparam int unsigned ValW     = 31;
  localparam int unsigned CountW   = 11;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 48;

  // Request kinds carried in s_tuser
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqLookup = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_PROBE
  } fsm_e;

  // One slot of the table as stored in memory
  typedef struct packed {
    logic            vld;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  // Memory port controls from the sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    slot_t            wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

// ----- src/linear_probe_key_value_table.sv -----
// Linear probing key/value table: one request in, one result out.
//
// Slave channel (s_*): one request per transaction. s_tuser_i carries the
// request kind (insert or lookup), s_tdata_i the key and the value.
// Master channel (m_*): one result per request. m_tuser_o carries the status,
// m_tdata_o the stored value on a hit and the entry count after the request.
//
// The table sits in one synchronous RAM holding valid bit, key and value per
// slot. When a request is taken, the sequencer reads one slot per cycle,
// starting at the home slot (low key bits) and walking upward with wrap.
// A request probes 1 up to 1024 slots through the single RAM read port; the
// next request is taken only once the result has moved to the output register.
// The result of the deciding probe lands in an output register, which drives
// the master channel.
// Reset: a clearing pass writes every slot empty, with s_tready_o low. When the
// receiver stalls, the result is held and the next request is still taken;
// its result waits in the deciding probe until the register frees.
// Depends on lpkv_pkg and lpkv_ram.
module linear_probe_key_value_table
  import lpkv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [InDataW-1:0]  s_tdata_i,  // key [30:0], value [61:31], zero [63:62]
  input  logic                s_tuser_i,  // req_type [0]
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,  // found_value [30:0], entry_count [41:31], zero [47:42]
  output logic [StatusW-1:0]  m_tuser_o   // status [2:0]
);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Capacity - 1);

  fsm_e             state_q, state_d;
  logic [AddrW-1:0] clr_addr_q;
  logic [AddrW-1:0] pos_q;
  logic [AddrW-1:0] probe_q;
  logic             lookup_q;
  logic [KeyW-1:0]  key_q;
  logic [ValW-1:0]  val_q;
  logic [CountW-1:0] count_q, count_d;
  logic             out_valid_q;
  status_e          out_status_q, status_d;
  logic [ValW-1:0]  out_found_q, found_d;
  logic [CountW-1:0] out_count_q;

  ram_req_t         ram_req;
  logic [SlotW-1:0] ram_rdata;
  slot_t            rd_slot;

  logic             accept;
  logic             hit, empty, last, finish, out_free, done;
  logic [KeyW-1:0]  in_key;
  logic [ValW-1:0]  in_val;

  assign in_key  = s_tdata_i[KeyW-1:0];
  assign in_val  = s_tdata_i[KeyW+ValW-1:KeyW];
  assign rd_slot = slot_t'(ram_rdata);

  lpkv_ram #(
    .Depth(Capacity),
    .Width(SlotW)
  ) u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(ram_rdata)
  );

  // Decode the probed slot
  always_comb begin
    hit      = rd_slot.vld && (rd_slot.key == key_q);
    empty    = !rd_slot.vld;
    last     = (probe_q == LastAddr);
    finish   = hit || empty || last;
    out_free = !out_valid_q || m_tready_i;
    done     = (state_q == FSM_PROBE) && finish && out_free;
    accept   = s_tvalid_i && s_tready_o;
  end

  // Form the result of the deciding probe
  always_comb begin
    found_d = '0;
    count_d = count_q;
    if (lookup_q == ReqLookup) begin
      if (hit) begin
        status_d = ST_FOUND;
        found_d  = rd_slot.value;
      end else begin
        status_d = ST_NOT_FOUND;
      end
    end else begin
      if (hit) begin
        status_d = ST_PRESENT;
      end else if (empty) begin
        status_d = ST_INSERTED;
        count_d  = count_q + CountW'(1);
      end else begin
        status_d = ST_FULL;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_CLEAR: if (clr_addr_q == LastAddr) state_d = FSM_IDLE;
      FSM_IDLE:  if (s_tvalid_i) state_d = FSM_PROBE;
      FSM_PROBE: if (done) state_d = FSM_IDLE;
      default:   state_d = FSM_CLEAR;
    endcase
  end

  // Handshake and memory controls
  always_comb begin
    s_tready_o    = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = pos_q;
    ram_req.wdata = '{vld: 1'b1, key: key_q, value: val_q};
    ram_req.re    = 1'b0;
    ram_req.raddr = finish ? pos_q : pos_q + AddrW'(1);
    case (state_q)
      FSM_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr_q;
        ram_req.wdata = '0;
      end
      FSM_IDLE: begin
        s_tready_o    = 1'b1;
        ram_req.re    = s_tvalid_i;
        ram_req.raddr = in_key[AddrW-1:0];
      end
      FSM_PROBE: begin
        ram_req.re = !done;
        ram_req.we = done && (lookup_q == ReqInsert) && empty;
      end
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_CLEAR;
      clr_addr_q  <= '0;
      probe_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == FSM_CLEAR) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
      if (accept) begin
        probe_q <= '0;
      end else if ((state_q == FSM_PROBE) && !finish) begin
        probe_q <= probe_q + AddrW'(1);
      end
      if (done) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q    <= in_key[AddrW-1:0];
      lookup_q <= s_tuser_i;
      key_q    <= in_key;
      val_q    <= in_val;
    end else if ((state_q == FSM_PROBE) && !finish) begin
      pos_q <= pos_q + AddrW'(1);
    end
    if (done) begin
      out_status_q <= status_d;
      out_found_q  <= found_d;
      out_count_q  <= count_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_status_q;
  assign m_tdata_o  = {(OutDataW - ValW - CountW)'(0), out_count_q, out_found_q};

endmodule

// ----- src/lpkv_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on lpkv_pkg for the request struct.
module lpkv_ram
  import lpkv_pkg::*;
#(
  parameter int unsigned Depth = Capacity,
  parameter int unsigned Width = SlotW
) (
  input  logic             clk_i,
  input  ram_req_t         req_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= Width'(req_i.wdata);
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

// ----- src/lpkv_checker.sv -----
// Port-level checks for the linear probing key/value table, bound to the top.
// Depends on lpkv_pkg.
module lpkv_checker
  import lpkv_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_tvalid_i,
  input logic                s_tready_o,
  input logic                m_tvalid_o,
  input logic                m_tready_i,
  input logic [OutDataW-1:0] m_tdata_o,
  input logic [StatusW-1:0]  m_tuser_o
);

  logic [ValW-1:0]   found_value;
  logic [CountW-1:0] entry_count;

  assign found_value = m_tdata_o[ValW-1:0];
  assign entry_count = m_tdata_o[ValW+CountW-1:ValW];

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("result changed while stalled");

  // One request at a time: a transaction closes the input for the next cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("request taken while probing");

  // Stored value shows only on a hit
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o != ST_FOUND) |-> found_value == '0)
    else $error("found_value nonzero without a hit");

  // Inserted, present or found implies a nonempty table within capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && ((m_tuser_o == ST_INSERTED) || (m_tuser_o == ST_PRESENT) ||
                   (m_tuser_o == ST_FOUND))
    |-> (entry_count != '0) && (entry_count <= CountW'(Capacity)))
    else $error("entry_count out of range");

endmodule

bind linear_probe_key_value_table lpkv_checker u_lpkv_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for linear_probe_key_value_table: a shadow table predicts
// each result, and a stream checker compares every transaction field by field.
// Depends on lpkv_pkg and the RTL of the block.
module tb_top;
  import lpkv_pkg::*;

  localparam logic [KeyW-1:0] KeyMax     = {KeyW{1'b1}};
  localparam int unsigned     StallLimit = 20000;
  localparam int unsigned     HoldCycles = 300;

  // Expected content of one result transaction
  typedef struct packed {
    status_e           status;
    logic [ValW-1:0]   found_value;
    logic [CountW-1:0] entry_count;
  } table_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready_o;
  logic [InDataW-1:0]  s_tdata = '0;  // key [30:0], value [61:31], zero [63:62]
  logic                s_tuser = ReqInsert;  // req_type [0]
  logic                m_tvalid_o;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata_o;  // found_value [30:0], entry_count [41:31], zero [47:42]
  logic [StatusW-1:0]  m_tuser_o;  // status [2:0]

  // Shadow copy of the table
  bit                  shadow_used [Capacity];
  logic [KeyW-1:0]     shadow_key [Capacity];
  logic [ValW-1:0]     shadow_value [Capacity];
  int unsigned         shadow_count = 0;

  table_result_t       pending_results [$];
  logic [KeyW-1:0]     stored_keys [$];
  table_result_t       want;
  int unsigned         mismatch_count = 0;
  int unsigned         quiet_cycles = 0;
  bit                  sender_burst = 1'b0;
  bit                  receiver_burst = 1'b0;
  int unsigned         receiver_hold_cycles = 0;

  linear_probe_key_value_table i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [KeyW-1:0] rand_field();
    return KeyW'($urandom() & 32'h7FFF_FFFF);
  endfunction

  // Probe the shadow table from the home slot and update it like the block does
  function automatic table_result_t apply_request(logic kind, logic [KeyW-1:0] key,
                                                  logic [ValW-1:0] value);
    table_result_t res;
    int unsigned   pos;
    res.found_value = '0;
    pos = key % Capacity;
    if (kind == ReqInsert) begin
      res.status = ST_FULL;
      for (int n = 0; n < Capacity; n++) begin
        if (!shadow_used[pos]) begin
          shadow_used[pos]  = 1'b1;
          shadow_key[pos]   = key;
          shadow_value[pos] = value;
          shadow_count++;
          res.status = ST_INSERTED;
          break;
        end
        if (shadow_key[pos] == key) begin
          res.status = ST_PRESENT;
          break;
        end
        pos = (pos + 1) % Capacity;
      end
    end else begin
      res.status = ST_NOT_FOUND;
      for (int n = 0; n < Capacity; n++) begin
        if (!shadow_used[pos]) break;
        if (shadow_key[pos] == key) begin
          res.status      = ST_FOUND;
          res.found_value = shadow_value[pos];
          break;
        end
        pos = (pos + 1) % Capacity;
      end
    end
    res.entry_count = CountW'(shadow_count);
    return res;
  endfunction

  // Offer one request, after a random gap unless in a sender burst, and record its prediction on acceptance
  task automatic send_request(input logic kind, input logic [KeyW-1:0] key,
                              input logic [ValW-1:0] value);
    int unsigned   gap;
    table_result_t res;
    gap = sender_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, value, key};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    res = apply_request(kind, key, value);
    pending_results.push_back(res);
    if (res.status == ST_INSERTED) stored_keys.push_back(key);
  endtask

  // Drop valid and hold the sender until every expected result has come
  task automatic wait_for_results();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KeyW-1:0] pick_stored_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // Lookups on the empty table
  task automatic test_empty_lookups();
    send_request(ReqLookup, '0, rand_field());
    send_request(ReqLookup, KeyMax, KeyMax);
  endtask

  // Extreme keys and values, duplicate insert, miss on an empty home slot
  task automatic test_insert_extremes();
    send_request(ReqInsert, '0, '0);
    send_request(ReqInsert, KeyMax, KeyMax);
    send_request(ReqInsert, 31'h2AAA_AAAA, 31'h5555_5555);
    send_request(ReqLookup, '0, KeyMax);
    send_request(ReqLookup, KeyMax, '0);
    send_request(ReqInsert, '0, KeyMax);
    send_request(ReqLookup, '0, rand_field());
    send_request(ReqLookup, 31'h5555_5555, rand_field());
  endtask

  // Chain keys off the top slot so probing wraps to slot zero and beyond
  task automatic test_probe_wrap();
    send_request(ReqInsert, 31'd1023, rand_field());
    send_request(ReqInsert, 31'd2047, rand_field());
    send_request(ReqInsert, 31'd3071, rand_field());
    send_request(ReqLookup, 31'd3071, rand_field());
    send_request(ReqLookup, 31'd5119, rand_field());
    send_request(ReqInsert, 31'd1023, rand_field());
    send_request(ReqLookup, 31'd1, rand_field());
    wait_for_results();
  endtask

  // Stall the output for a long stretch while the sender offers requests with no gap
  task automatic test_output_backpressure();
    sender_burst         = 1'b1;
    receiver_hold_cycles = HoldCycles;
    for (int i = 0; i < 10; i++) begin
      if (($urandom_range(0, 1) == 0) || (stored_keys.size() == 0))
        send_request(ReqInsert, rand_field(), rand_field());
      else
        send_request(ReqLookup, pick_stored_key(), rand_field());
    end
    sender_burst = 1'b0;
    wait_for_results();
  endtask

  // Mixed traffic: mostly hits and new keys, plus a crowded window of home slots
  task automatic test_random_traffic(input int unsigned count);
    int unsigned      pick;
    logic [KeyW-1:0]  key;
    logic [AddrW-1:0] crowd_base;
    crowd_base = AddrW'($urandom_range(0, Capacity - 1));
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      if (i == count / 2) wait_for_results();
      pick = $urandom_range(0, 99);
      key  = rand_field();
      if ((pick >= 95) || ((pick >= 30) && (pick < 40)))
        key[AddrW-1:0] = crowd_base + AddrW'($urandom_range(0, 15));
      else if ((pick >= 40) && (pick < 80) && (stored_keys.size() != 0))
        key = pick_stored_key();
      send_request((pick < 50) ? ReqInsert : ReqLookup, key, rand_field());
    end
    sender_burst = 1'b0;
    wait_for_results();
  endtask

  // Fill every empty slot through its own home, then hit the full table
  task automatic test_fill_to_full();
    logic [KeyW-1:0] key;
    for (int slot = 0; slot < Capacity; slot++) begin
      if (!shadow_used[slot]) begin
        key            = rand_field();
        key[AddrW-1:0] = slot[AddrW-1:0];
        send_request(ReqInsert, key, rand_field());
      end
    end
    send_request(ReqInsert, rand_field(), rand_field());
    send_request(ReqInsert, pick_stored_key(), rand_field());
    send_request(ReqLookup, rand_field(), rand_field());
    send_request(ReqLookup, pick_stored_key(), rand_field());
    send_request(ReqLookup, KeyMax, rand_field());
    wait_for_results();
  endtask

  // Receiver: random stalls, burst stretches and one long hold-off on request
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      if (receiver_hold_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (receiver_hold_cycles) @(negedge clk_i);
        receiver_hold_cycles = 0;
      end
      if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
      stall = receiver_burst ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_tvalid_o && m_tready)) @(posedge clk_i);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d", m_tuser_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tuser_o);
          mismatch_count++;
        end
        if (m_tdata_o[ValW-1:0] !== want.found_value) begin
          $error("found_value: expected %0d, actual %0d", want.found_value,
                 m_tdata_o[ValW-1:0]);
          mismatch_count++;
        end
        if (m_tdata_o[ValW+CountW-1:ValW] !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count,
                 m_tdata_o[ValW+CountW-1:ValW]);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready_o) || (m_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_lookups();
    test_insert_extremes();
    test_probe_wrap();
    test_output_backpressure();
    test_random_traffic(950);
    test_fill_to_full();
    wait_for_results();
    // Allow a full-table probe to surface any stray result
    repeat (Capacity + 64) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
